### design/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// shared types, constants and helpers for the camera point projection core
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int NUM_REGS   = 6;
  localparam int REG_IDX_W  = 3;
  localparam int REG_W      = 64;
  localparam int COORD_W    = 32;
  localparam int DEPTH_W    = 31;
  localparam int SCALED_W   = 41;   // |v| * 1000 fits in 41 bits
  localparam int DIV_STAGES = 32;   // one quotient bit per stage
  localparam logic [9:0] PROJ_SCALE = 10'd1000;

  localparam logic [REG_IDX_W-1:0] REG_ROW_X_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_X_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_A = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Y_B = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z_A = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_Z_B = 3'd5;

  localparam logic [REG_W-1:0] RST_ROW_X_A = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW_X_B = 64'h0;
  localparam logic [REG_W-1:0] RST_ROW_Y_A = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW_Y_B = 64'h0;
  localparam logic [REG_W-1:0] RST_ROW_Z_A = 64'h0;
  localparam logic [REG_W-1:0] RST_ROW_Z_B = 64'h0000_0000_0001_0000;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // matrix row: three coefficients and a translation
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t row_t [4];
  typedef row_t   mat_t [3];

  // saturate a 51-bit row sum to the coordinate range
  function automatic coord_t sat_coord(input logic signed [50:0] v);
    coord_t res;
    if (v > 51'(COORD_MAX)) begin
      res = COORD_MAX;
    end else if (v < 51'(COORD_MIN)) begin
      res = COORD_MIN;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### design/cpp_xform.sv
// ----------------------------------------------------------------------------
// cpp_xform
// two-stage view transform: nine products, then row sums with saturation
// ----------------------------------------------------------------------------
module cpp_xform import cpp_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  mat_t   mat,
  input  coord_t pt_x,
  input  coord_t pt_y,
  input  coord_t pt_z,
  output coord_t vx,
  output coord_t vy,
  output coord_t vz
);

  logic signed [63:0] prod_r [3][3];
  coord_t             tr_r   [3];
  coord_t             row_r  [3];
  coord_t             row_nxt [3];

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= 64'(mat[r][0]) * 64'(pt_x);
        prod_r[r][1] <= 64'(mat[r][1]) * 64'(pt_y);
        prod_r[r][2] <= 64'(mat[r][2]) * 64'(pt_z);
        tr_r[r]      <= mat[r][3];
      end
    end
  end

  // stage 2: floor of exact sum over 2^16, plus translation
  always_comb begin
    logic signed [65:0] sum;
    logic signed [50:0] tot;
    for (int r = 0; r < 3; r++) begin
      sum = 66'(prod_r[r][0]) + 66'(prod_r[r][1]) + 66'(prod_r[r][2]);
      tot = 51'(sum >>> 16) + 51'(tr_r[r]);
      row_nxt[r] = sat_coord(tot);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        row_r[r] <= row_nxt[r];
      end
    end
  end

  assign vx = row_r[0];
  assign vy = row_r[1];
  assign vz = row_r[2];

endmodule

### design/cpp_div.sv
// ----------------------------------------------------------------------------
// cpp_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module cpp_div import cpp_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SCALED_W-1:0] mag_i,   // dividend is mag_i * 2^16
  input  logic                neg_i,
  input  logic [DEPTH_W-1:0]  den_i,
  output logic [COORD_W-1:0]  quo_o,
  output logic                neg_o,
  output logic                ovf_o,
  output logic [DEPTH_W-1:0]  den_o
);

  logic [DEPTH_W-1:0] rem_r [DIV_STAGES];
  logic [31:0]        low_r [DIV_STAGES];
  logic [31:0]        quo_r [DIV_STAGES];
  logic [DEPTH_W-1:0] den_r [DIV_STAGES];
  logic               neg_r [DIV_STAGES];
  logic               ovf_r [DIV_STAGES];

  // quotient of 2^32 or more saturates anyway
  logic               ovf_in;
  logic [DEPTH_W-1:0] rem_in;
  logic [31:0]        low_in;

  assign ovf_in = {6'd0, mag_i} >= {den_i, 16'd0};
  assign rem_in = DEPTH_W'(mag_i >> 16);
  assign low_in = {mag_i[15:0], 16'd0};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DEPTH_W-1:0] rem_src;
    logic [31:0]        low_src;
    logic [31:0]        quo_src;
    logic [DEPTH_W-1:0] den_src;
    logic               neg_src;
    logic               ovf_src;
    logic [31:0]        trial;
    logic               ge;
    logic [DEPTH_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_src = rem_in;
      assign low_src = low_in;
      assign quo_src = '0;
      assign den_src = den_i;
      assign neg_src = neg_i;
      assign ovf_src = ovf_in;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign low_src = low_r[k-1];
      assign quo_src = quo_r[k-1];
      assign den_src = den_r[k-1];
      assign neg_src = neg_r[k-1];
      assign ovf_src = ovf_r[k-1];
    end

    assign trial   = {rem_src, low_src[31]};
    assign ge      = trial >= {1'b0, den_src};
    assign rem_nxt = ge ? DEPTH_W'(trial - {1'b0, den_src}) : trial[DEPTH_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {low_src[30:0], 1'b0};
        quo_r[k] <= {quo_src[30:0], ge};
        den_r[k] <= den_src;
        neg_r[k] <= neg_src;
        ovf_r[k] <= ovf_src;
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];
  assign neg_o = neg_r[DIV_STAGES-1];
  assign ovf_o = ovf_r[DIV_STAGES-1];
  assign den_o = den_r[DIV_STAGES-1];

endmodule

### design/camera_point_projection_core.sv
// ----------------------------------------------------------------------------
// camera_point_projection_core
// view transform of a Q16.16 point followed by perspective divide by depth
// ----------------------------------------------------------------------------
// pipeline from input beat to output beat: 2 transform, 1 prep,
//   32 divider stages, 1 output register
// throughput: one point per cycle, set by the fully pipelined multipliers
//   and the bit-per-stage divider; the whole pipe holds while out is stalled
// reset: synchronous active-low rst_n clears all valid bits and loads the
//   matrix registers with their defaults; cfg_ready is always high
module camera_point_projection_core import cpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input points
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [95:0]          in_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  // projected results
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [95:0]          out_tdata,  // screen_x[31:0], screen_y[63:32],
                                           // depth[94:64], zero pad[95]
  output logic                 out_tuser,  // visible[0]
  // matrix register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int PIPE = 3 + DIV_STAGES;   // valid bits ahead of the output reg

  // matrix registers
  logic [REG_W-1:0] regs_r [NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[0] <= RST_ROW_X_A;
      regs_r[1] <= RST_ROW_X_B;
      regs_r[2] <= RST_ROW_Y_A;
      regs_r[3] <= RST_ROW_Y_B;
      regs_r[4] <= RST_ROW_Z_A;
      regs_r[5] <= RST_ROW_Z_B;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_X_A: regs_r[0] <= cfg_data;
        REG_ROW_X_B: regs_r[1] <= cfg_data;
        REG_ROW_Y_A: regs_r[2] <= cfg_data;
        REG_ROW_Y_B: regs_r[3] <= cfg_data;
        REG_ROW_Z_A: regs_r[4] <= cfg_data;
        REG_ROW_Z_B: regs_r[5] <= cfg_data;
        default: ;  // unknown index is dropped
      endcase
    end
  end

  // unpack rows: low half then high half of each register pair
  mat_t mat;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = regs_r[2*r][31:0];
      mat[r][1] = regs_r[2*r][63:32];
      mat[r][2] = regs_r[2*r+1][31:0];
      mat[r][3] = regs_r[2*r+1][63:32];
    end
  end

  // global advance: the pipe moves when the output register is free or taken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // valid bits, one per stage
  logic [PIPE-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE-2:0], in_tvalid};
    end
  end

  // transform, stages 1 and 2
  coord_t vx, vy, vz;
  cpp_xform u_xform (
    .clk  (clk),
    .en   (en),
    .mat  (mat),
    .pt_x (in_tdata[31:0]),
    .pt_y (in_tdata[63:32]),
    .pt_z (in_tdata[95:64]),
    .vx   (vx),
    .vy   (vy),
    .vz   (vz)
  );

  // stage 3: depth, visibility and scaled magnitudes
  logic [DEPTH_W-1:0]  den_r;
  logic                vis_r;
  logic [SCALED_W-1:0] mag_x_r, mag_y_r;
  logic                neg_x_r, neg_y_r;
  logic [COORD_W-1:0]  abs_x, abs_y;
  logic                vis_nxt;
  logic [DEPTH_W-1:0]  den_nxt;

  assign abs_x   = vx[COORD_W-1] ? COORD_W'(-vx) : vx;
  assign abs_y   = vy[COORD_W-1] ? COORD_W'(-vy) : vy;
  assign vis_nxt = vz[COORD_W-1];
  // negating the most negative depth clamps to the top of the 31-bit range
  always_comb begin
    if (!vis_nxt) begin
      den_nxt = '0;
    end else if (vz == COORD_MIN) begin
      den_nxt = '1;
    end else begin
      den_nxt = DEPTH_W'(-vz);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= den_nxt;
      vis_r   <= vis_nxt;
      mag_x_r <= SCALED_W'(abs_x * PROJ_SCALE);
      mag_y_r <= SCALED_W'(abs_y * PROJ_SCALE);
      neg_x_r <= vx[COORD_W-1];
      neg_y_r <= vy[COORD_W-1];
    end
  end

  // visibility rides alongside the divider
  logic vis_dly_r [DIV_STAGES];
  always_ff @(posedge clk) begin
    if (en) begin
      vis_dly_r[0] <= vis_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vis_dly_r[k] <= vis_dly_r[k-1];
      end
    end
  end

  logic [COORD_W-1:0] quo_x, quo_y;
  logic               dneg_x, dneg_y, ovf_x, ovf_y;
  logic [DEPTH_W-1:0] den_x, den_y;

  cpp_div u_div_x (
    .clk   (clk),
    .en    (en),
    .mag_i (mag_x_r),
    .neg_i (neg_x_r),
    .den_i (den_r),
    .quo_o (quo_x),
    .neg_o (dneg_x),
    .ovf_o (ovf_x),
    .den_o (den_x)
  );

  cpp_div u_div_y (
    .clk   (clk),
    .en    (en),
    .mag_i (mag_y_r),
    .neg_i (neg_y_r),
    .den_i (den_r),
    .quo_o (quo_y),
    .neg_o (dneg_y),
    .ovf_o (ovf_y),
    .den_o (den_y)
  );

  // sign and saturation of a quotient magnitude, truncated toward zero
  function automatic coord_t fix_quo(input logic [COORD_W-1:0] q, input logic n,
                                     input logic o);
    coord_t res;
    if (!n) begin
      res = (o || q[COORD_W-1]) ? COORD_MAX : q;
    end else begin
      res = (o || q > COORD_W'(COORD_MIN)) ? COORD_MIN : COORD_W'(-q);
    end
    return res;
  endfunction

  // output register
  logic [95:0] tdata_r;
  logic        tuser_r;
  logic        tvalid_r;
  logic        vis_last;

  assign vis_last = vis_dly_r[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (en) begin
      tvalid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tuser_r <= vis_last;
      if (vis_last) begin
        tdata_r <= {1'b0, den_x, fix_quo(quo_y, dneg_y, ovf_y),
                    fix_quo(quo_x, dneg_x, ovf_x)};
      end else begin
        // behind or at the camera: all fields zero
        tdata_r <= '0;
      end
    end
  end

  // both dividers carry the same depth
  logic unused_den_y;
  assign unused_den_y = ^den_y;

  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r & ~(unused_den_y & 1'b0);

endmodule

### design/cpp_checker.sv
// ----------------------------------------------------------------------------
// cpp_checker
// port-level checks for the camera point projection core
// ----------------------------------------------------------------------------
module cpp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a stalled output also stalls the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // a point behind the camera carries all-zero fields
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 96'd0)
    else $error("hidden point has nonzero fields");

  // a visible point has positive depth
  a_vis_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[94:64] != 31'd0 && !out_tdata[95])
    else $error("visible point with zero depth");

endmodule

bind camera_point_projection_core cpp_checker u_cpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/projection_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// projection_checker
// watches the point, result and matrix write channels of the projection core,
// keeps its own copy of the matrix and predicts every projected result, then
// compares each result beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module projection_checker import cpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [95:0]          in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [95:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   visible_count
);

  typedef struct packed {
    logic                  visible;
    logic signed [31:0]    screen_x;
    logic signed [31:0]    screen_y;
    logic [DEPTH_W-1:0]    depth;
  } proj_t;

  logic [REG_W-1:0] matrix_regs [NUM_REGS];
  proj_t            projected_q [$];

  // floor of the exact row sum over 2^16, saturated
  function automatic logic signed [31:0] view_row(input int r, input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z);
    logic signed [31:0] c0, c1, c2, t;
    logic signed [67:0] s;
    c0 = matrix_regs[2*r][31:0];
    c1 = matrix_regs[2*r][63:32];
    c2 = matrix_regs[2*r+1][31:0];
    t  = matrix_regs[2*r+1][63:32];
    s  = 68'(c0) * 68'(x) + 68'(c1) * 68'(y) + 68'(c2) * 68'(z) + (68'(t) <<< 16);
    s  = s >>> 16;
    if (s > 68'sh7FFF_FFFF) return COORD_MAX;
    if (s < -68'sh8000_0000) return COORD_MIN;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_quot(input longint q);
    if (q > 64'sh7FFF_FFFF) return COORD_MAX;
    if (q < -64'sh8000_0000) return COORD_MIN;
    return q[31:0];
  endfunction

  function automatic proj_t project_point(input logic [95:0] p);
    proj_t  res;
    logic signed [31:0] vx, vy, vz;
    longint d;
    vx = view_row(0, p[31:0], p[63:32], p[95:64]);
    vy = view_row(1, p[31:0], p[63:32], p[95:64]);
    vz = view_row(2, p[31:0], p[63:32], p[95:64]);
    d  = -longint'(vz);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    res = '0;
    // behind or at the camera: everything zero
    if (d > 0) begin
      res.visible  = 1'b1;
      res.screen_x = sat_quot((longint'(vx) * 64'sd65536000) / d);
      res.screen_y = sat_quot((longint'(vy) * 64'sd65536000) / d);
      res.depth    = d[DEPTH_W-1:0];
    end
    return res;
  endfunction

  assign pending = projected_q.size();

  always @(posedge clk) begin
    proj_t exp_r;
    if (!rst_n) begin
      matrix_regs[0] <= RST_ROW_X_A;
      matrix_regs[1] <= RST_ROW_X_B;
      matrix_regs[2] <= RST_ROW_Y_A;
      matrix_regs[3] <= RST_ROW_Y_B;
      matrix_regs[4] <= RST_ROW_Z_A;
      matrix_regs[5] <= RST_ROW_Z_B;
    end else begin
      // unknown register index is dropped
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        matrix_regs[cfg_index] <= cfg_data;
      if (in_tvalid && in_tready)
        projected_q.push_back(project_point(in_tdata));
      if (out_tvalid && out_tready) begin
        if (projected_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_r = projected_q.pop_front();
          if (exp_r.visible) visible_count++;
          if (out_tuser !== exp_r.visible) begin
            $error("visible: expected %0d actual %0d", exp_r.visible, out_tuser);
            fail_count++;
          end
          if (out_tdata[31:0] !== exp_r.screen_x) begin
            $error("screen_x: expected %0d actual %0d", exp_r.screen_x,
                   $signed(out_tdata[31:0]));
            fail_count++;
          end
          if (out_tdata[63:32] !== exp_r.screen_y) begin
            $error("screen_y: expected %0d actual %0d", exp_r.screen_y,
                   $signed(out_tdata[63:32]));
            fail_count++;
          end
          if (out_tdata[94:64] !== exp_r.depth) begin
            $error("depth: expected %0d actual %0d", exp_r.depth, out_tdata[94:64]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    fail_count    = 0;
    visible_count = 0;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives points and matrix settings into the projection core with random
// idling on both sides; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top import cpp_pkg::*;;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [95:0]          in_tdata;    // point_x[31:0], point_y[63:32], point_z[95:64]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [95:0]          out_tdata;   // screen_x[31:0], screen_y[63:32], depth[94:64]
  logic                 out_tuser;   // visible[0]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  int  fail_count;
  int  pending;
  int  visible_count;
  int  points_sent;
  int  settings_done;
  int  quiet_cycles;
  bit  quiet;         // no idling in the last part
  bit  hold_req;      // asks the receiver for one long hold-off

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 50;

  camera_point_projection_core dut (.*);

  projection_checker u_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        if (!quiet) repeat ($urandom_range(0, 20)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end
    end
  end

  // one point beat; valid stays high into the next beat when no gap follows
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    logic rdy;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    points_sent++;
  endtask

  // wait until the core is drained before touching the matrix
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0:       return $urandom();
      1:       return 32'(int'($urandom_range(0, 2097151)) - 1048576);
      2:       return 32'(int'($urandom_range(0, 65535)) - 32768);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // random points; mostly modest sizes so most land in front of the camera
  task automatic random_points(input int n, input int phase_mode);
    int m;
    repeat (n) begin
      m = $urandom_range(0, 9);
      m = (m < 3) ? 0 : (m < 6) ? 1 : (m < 9) ? 2 : 3;
      if (phase_mode == 1 && m == 0) m = 2;
      send_point(rand_coord(m), rand_coord(m), rand_coord(m));
    end
  endtask

  // matrix with small random entries, q16.16 in about +-4
  function automatic logic [31:0] small_entry();
    return 32'(int'($urandom_range(0, 524287)) - 262144);
  endfunction

  task automatic load_matrix(input logic [31:0] m [12]);
    for (int r = 0; r < NUM_REGS; r++)
      write_reg(REG_IDX_W'(r), {m[2*r+1], m[2*r]});
    settings_done++;
  endtask

  initial begin
    logic [31:0] m [12];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    points_sent   = 0;
    settings_done = 1;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset matrix: view = (x, y, z), depth = -z
    send_point(32'h0, 32'h0, 32'h0);                        // at the camera
    send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000); // plain visible
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF); // depth 1, screen saturates
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000); // depth saturates
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // behind the camera
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001); // behind, tiny
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFF0_0000); // truncation toward zero
    send_point(32'h0, 32'h0, 32'hFFFF_FFFF);
    wait_idle();

    // extreme matrix: every entry at max, then at min, rows overflow
    for (int i = 0; i < 12; i++) m[i] = 32'h7FFF_FFFF;
    load_matrix(m);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h0, 32'h0);
    wait_idle();
    for (int i = 0; i < 12; i++) m[i] = 32'h8000_0000;
    load_matrix(m);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h0001_0000);
    wait_idle();

    // unknown indexes must leave the matrix alone
    write_reg(3'd6, {$urandom(), $urandom()});
    write_reg(3'd7, {$urandom(), $urandom()});
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
    send_point(32'h0, 32'h0, 32'hFFFF_FFFF);
    wait_idle();

    // camera looking down -z from z = +10, fill up the pipe with a long stall
    m = '{32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 32'hFFFF_0000, 32'hFFF6_0000};
    m[10] = 32'h0001_0000;   // depth = 10 - z, so the camera sits at z = +10
    load_matrix(m);
    hold_req = 1'b1;
    random_points(320, 1);
    wait_idle();

    // reset matrix again, explicitly written
    m = '{32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 0};
    load_matrix(m);
    random_points(300, 0);
    wait_idle();

    // a few random small matrices with a camera offset
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 12; i++) m[i] = small_entry();
      m[11] = 32'(-int'($urandom_range(0, 32'h0040_0000)));
      load_matrix(m);
      random_points(250, 1);
      wait_idle();
    end

    // fully random 64-bit registers
    for (int r = 0; r < NUM_REGS; r++) write_reg(REG_IDX_W'(r), {$urandom(), $urandom()});
    settings_done++;
    random_points(200, 0);
    wait_idle();

    // last part: no idling on either side
    for (int i = 0; i < 12; i++) m[i] = small_entry();
    load_matrix(m);
    quiet = 1'b1;
    random_points(300, 1);
    in_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d points over %0d matrix settings, %0d results visible",
             points_sent, settings_done, visible_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
